// ----- hdl/srsw_pkg.sv -----
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int SEQ_W          = 16;
    localparam int WIN_W          = 4;
    localparam int DEF_MAX_WINDOW = 8;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = 4'd4;

    localparam logic REQ_ROUND   = 1'b0;
    localparam logic REQ_ACK     = 1'b1;

    localparam logic KIND_SEND   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic REG_WINDOW  = 1'b0;
    localparam logic REG_TOTAL   = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [SEQ_W-1:0] ack_seq;
    } t_request;

    typedef struct packed {
        logic             result_kind;
        logic [SEQ_W-1:0] send_seq;
        logic [SEQ_W-1:0] window_base;
        logic             all_done;
        logic             last_of_run;
    } t_result;

    typedef struct packed {
        logic load_pend;
        logic shift_pend;
        logic shift_mark;
        logic set_mark;
    } t_cell_ctl;

endpackage

// ----- hdl/selective_repeat_sender_window_top.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_top
// Sender window of selective repeat ARQ: transmit rounds over the window and
// acknowledgements that slide the base over a row of slot cells.
//
//   Channel   Handshake                  Payload
//   request   start / busy               i_req  (req_type, ack_seq)
//   result    o_strobe, one cycle        o_res  (kind, seq, base, done, last)
//   config    APB psel/penable/pready    window_size, total_packets
//
// A round scans the pending row over W cells, W being the effective window,
// one cell per cycle as the row shifts, and then forms its final result.
// An acknowledgement sets its mark and then slides the base over S slots,
// one slide of the mark row per cycle.
// Reset is synchronous and clears the base and all marks at once.
// Results cannot be stalled; busy stays high until the final result is formed.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_top #(
    parameter int MAX_WINDOW = srsw_pkg::DEF_MAX_WINDOW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  srsw_pkg::t_request           i_req,
    output logic                         o_strobe,
    output srsw_pkg::t_result            o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srsw_pkg::APB_AW-1:0]  paddr,
    input  logic [srsw_pkg::APB_DW-1:0]  pwdata,
    output logic [srsw_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import srsw_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MARK  = 3'd1;
    localparam logic [2:0] ST_SLIDE = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [WIN_W-1:0] r_win;
    logic [SEQ_W-1:0] r_total;
    logic [2:0]       r_state,    n_state;
    logic [SEQ_W-1:0] r_base,     n_base;
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic             r_held_v,   n_held_v;
    logic [CNT_W-1:0] r_held_off, n_held_off;
    logic [SEQ_W-1:0] r_ack_seq,  n_ack_seq;
    logic             r_strobe,   n_strobe;
    t_result          r_out,      n_out;

    t_cell_ctl        w_ctl;
    logic [MAX_WINDOW-1:0] w_mark;
    logic [MAX_WINDOW-1:0] w_pend;
    logic [CMP_W-1:0] w_win_c;
    logic [CMP_W-1:0] w_win_1;
    logic [CNT_W-1:0] w_eff_w;
    logic [SEQ_W-1:0] w_rem;
    logic [SEQ_W-1:0] w_ack_d;
    logic             w_ack_ok;
    logic             w_done;
    logic             w_cfg_wr;

    assign w_win_c = CMP_W'(r_win);
    assign w_win_1 = (w_win_c == '0) ? CMP_W'(1) : w_win_c;
    assign w_eff_w = (w_win_1 > CMP_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                     : CNT_W'(w_win_1);

    assign w_done   = (r_base >= r_total);
    assign w_rem    = w_done ? '0 : (r_total - r_base);
    assign w_ack_d  = r_ack_seq - r_base;
    assign w_ack_ok = (r_ack_seq >= r_base) && (w_ack_d < SEQ_W'(w_eff_w))
                      && (r_ack_seq < r_total);

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
            logic w_next_mark;
            logic w_next_pend;
            if (g == MAX_WINDOW - 1) begin : g_tail
                assign w_next_mark = 1'b0;
                assign w_next_pend = 1'b0;
            end else begin : g_body
                assign w_next_mark = w_mark[g + 1];
                assign w_next_pend = w_pend[g + 1];
            end
            srsw_cell #(
                .MAX_WINDOW(MAX_WINDOW),
                .CELL_IDX  (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_eff_w    (w_eff_w),
                .i_ack_off  (w_ack_d[CNT_W-1:0]),
                .i_rem      (w_rem),
                .i_next_mark(w_next_mark),
                .i_next_pend(w_next_pend),
                .o_mark     (w_mark[g]),
                .o_pend     (w_pend[g])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_held_v   = r_held_v;
        n_held_off = r_held_off;
        n_ack_seq  = r_ack_seq;
        n_strobe   = 1'b0;
        n_out      = r_out;
        w_ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_req.req_type == REQ_ROUND) begin
                        w_ctl.load_pend = 1'b1;
                        n_cnt           = '0;
                        n_held_v        = 1'b0;
                        n_state         = ST_SCAN;
                    end else begin
                        n_ack_seq = i_req.ack_seq;
                        n_state   = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                w_ctl.set_mark = w_ack_ok;
                n_state        = ST_SLIDE;
            end
            ST_SLIDE: begin
                if (!w_done && w_mark[0]) begin
                    w_ctl.shift_mark = 1'b1;
                    n_base           = r_base + SEQ_W'(1);
                end else begin
                    n_strobe          = 1'b1;
                    n_out.result_kind = KIND_STATUS;
                    n_out.send_seq    = '0;
                    n_out.window_base = r_base;
                    n_out.all_done    = w_done;
                    n_out.last_of_run = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (w_pend[0]) begin
                    if (r_held_v) begin
                        n_strobe          = 1'b1;
                        n_out.result_kind = KIND_SEND;
                        n_out.send_seq    = r_base + SEQ_W'(r_held_off);
                        n_out.window_base = r_base;
                        n_out.all_done    = w_done;
                        n_out.last_of_run = 1'b0;
                    end
                    n_held_v   = 1'b1;
                    n_held_off = r_cnt;
                end
                w_ctl.shift_pend = 1'b1;
                if (r_cnt == (w_eff_w - CNT_W'(1))) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FLUSH: begin
                n_strobe          = 1'b1;
                n_out.window_base = r_base;
                n_out.all_done    = w_done;
                n_out.last_of_run = 1'b1;
                if (r_held_v) begin
                    n_out.result_kind = KIND_SEND;
                    n_out.send_seq    = r_base + SEQ_W'(r_held_off);
                end else begin
                    n_out.result_kind = KIND_STATUS;
                    n_out.send_seq    = '0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_base   <= '0;
            r_cnt    <= '0;
            r_held_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_cnt    <= n_cnt;
            r_held_v <= n_held_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_off <= n_held_off;
        r_ack_seq  <= n_ack_seq;
        r_out      <= n_out;
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= WIN_RESET;
            r_total <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_WINDOW) begin
                r_win <= pwdata[WIN_W-1:0];
            end else begin
                r_total <= pwdata[SEQ_W-1:0];
            end
        end
    end

    assign prdata   = (paddr[2] == REG_WINDOW) ? APB_DW'(r_win) : APB_DW'(r_total);
    assign pready   = 1'b1;
    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last_of_run) |-> (o_res.result_kind == KIND_SEND))
        else $error("status result not marked last");

    a_status_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_res.result_kind == KIND_STATUS)) |-> (o_res.send_seq == '0))
        else $error("status result carries a sequence number");

    a_base_slide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_base != $past(r_base))) |->
        (($past(r_state) == ST_SLIDE) && (r_base == $past(r_base) + SEQ_W'(1))))
        else $error("base moved outside a slide step");

endmodule

// ----- hdl/srsw_cell.sv -----
// ----------------------------------------------------------------------------
// srsw_cell
// One window slot, relative to the base: its acknowledged mark and its
// pending-transmit bit, both of which shift toward the base cell.
// ----------------------------------------------------------------------------
module srsw_cell #(
    parameter int MAX_WINDOW = srsw_pkg::DEF_MAX_WINDOW,
    parameter int CELL_IDX   = 0,
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srsw_pkg::t_cell_ctl         i_ctl,
    input  logic [CNT_W-1:0]            i_eff_w,
    input  logic [CNT_W-1:0]            i_ack_off,
    input  logic [srsw_pkg::SEQ_W-1:0]  i_rem,
    input  logic                        i_next_mark,
    input  logic                        i_next_pend,
    output logic                        o_mark,
    output logic                        o_pend
);
    import srsw_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C   = CNT_W'(CELL_IDX);
    localparam logic [SEQ_W-1:0] IDX_SEQ = SEQ_W'(CELL_IDX);

    logic r_mark;
    logic r_pend;
    logic n_mark;
    logic n_pend;

    always_comb begin
        n_mark = r_mark;
        if (i_ctl.shift_mark) begin
            n_mark = i_next_mark;
        end else if (i_ctl.set_mark && (i_ack_off == IDX_C)) begin
            n_mark = 1'b1;
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (i_ctl.load_pend) begin
            n_pend = !r_mark && (IDX_C < i_eff_w) && (IDX_SEQ < i_rem);
        end else if (i_ctl.shift_pend) begin
            n_pend = i_next_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_mark <= n_mark;
            r_pend <= n_pend;
        end
    end

    assign o_mark = r_mark;
    assign o_pend = r_pend;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the selective repeat sender window. A directed
// table covers reset values, register extremes, ignored, repeated and
// out-of-window acknowledgements and full windows. Random phases follow,
// mostly transmit rounds and in-window acknowledgements, with noise mixed in.
// Each result is checked against a cycle-free window model or the table row.
// ----------------------------------------------------------------------------
module testbench;
    import srsw_pkg::*;

    localparam int MAXW = DEF_MAX_WINDOW;
    localparam logic [APB_AW-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_TOTAL  = {REG_TOTAL, 2'b00};
    localparam int RANDOM_ITEMS = 107;

    typedef enum logic [1:0] {ROW_ITEM, ROW_SET_WINDOW, ROW_SET_TOTAL} t_row_op;

    typedef struct {
        t_row_op  op;
        logic [APB_DW-1:0] value;
        t_request req;
        bit       typed;
        t_result  want;
    } t_plan_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_request          i_req;
    logic              o_strobe;
    t_result           o_res;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic [WIN_W-1:0]  cfg_window;
    logic [SEQ_W-1:0]  cfg_total;
    int unsigned       win_base;
    bit                acked [MAXW];
    t_result           expected_results [$];
    int                mismatches;
    int                burst_left;
    t_plan_row         plan [$];

    selective_repeat_sender_window_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned eff_window();
        if (cfg_window == '0) begin
            return 1;
        end
        if (cfg_window > MAXW) begin
            return MAXW;
        end
        return cfg_window;
    endfunction

    function automatic t_result make_result(logic kind, int unsigned seq, logic last);
        t_result r;
        r.result_kind = kind;
        r.send_seq    = SEQ_W'(seq);
        r.window_base = SEQ_W'(win_base);
        r.all_done    = (win_base >= cfg_total);
        r.last_of_run = last;
        return r;
    endfunction

    function automatic t_result status(logic [SEQ_W-1:0] base, logic done);
        return '{KIND_STATUS, '0, base, done, 1'b1};
    endfunction

    // Advances the window model by one transaction and returns what it emits.
    function automatic void window_step(input t_request r, ref t_result run [$]);
        int unsigned w;
        int unsigned s;
        w = eff_window();
        run.delete();
        if (r.req_type == REQ_ROUND) begin
            if (win_base < cfg_total) begin
                for (int unsigned i = win_base; i < win_base + w && i < cfg_total; i++) begin
                    if (!acked[i % MAXW]) begin
                        run.push_back(make_result(KIND_SEND, i, 1'b0));
                    end
                end
            end
            if (run.size() == 0) begin
                run.push_back(make_result(KIND_STATUS, 0, 1'b1));
            end else begin
                run[run.size()-1].last_of_run = 1'b1;
            end
        end else begin
            s = r.ack_seq;
            if (s >= win_base && s < win_base + w && s < cfg_total) begin
                acked[s % MAXW] = 1'b1;
            end
            for (int k = 0; k < MAXW; k++) begin
                if (win_base >= cfg_total || !acked[win_base % MAXW]) begin
                    break;
                end
                acked[win_base % MAXW] = 1'b0;
                win_base++;
            end
            run.push_back(make_result(KIND_STATUS, 0, 1'b1));
        end
    endfunction

    task automatic report(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display({"%0t: %s: expected kind=%0d seq=%0d base=%0d done=%0d last=%0d,",
                      " got kind=%0d seq=%0d base=%0d done=%0d last=%0d"},
                     $realtime, what, want.result_kind, want.send_seq, want.window_base,
                     want.all_done, want.last_of_run, got.result_kind, got.send_seq,
                     got.window_base, got.all_done, got.last_of_run);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        string   bad;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", '0, o_res);
            end else begin
                want = expected_results.pop_front();
                bad  = "";
                if (o_res.result_kind !== want.result_kind) bad = {bad, " kind"};
                if (o_res.send_seq    !== want.send_seq)    bad = {bad, " seq"};
                if (o_res.window_base !== want.window_base) bad = {bad, " base"};
                if (o_res.all_done    !== want.all_done)    bad = {bad, " done"};
                if (o_res.last_of_run !== want.last_of_run) bad = {bad, " last"};
                if (bad != "") begin
                    report({"mismatch in", bad}, want, o_res);
                end
            end
        end
    end

    task automatic send_item(t_request r, bit typed, t_result want);
        t_result run [$];
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        window_step(r, run);
        if (typed) begin
            run.delete();
            run.push_back(want);
        end
        foreach (run[k]) begin
            expected_results.push_back(run[k]);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_WINDOW) begin
            cfg_window = data[WIN_W-1:0];
        end else begin
            cfg_total = data[SEQ_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic sender_gap();
        if (burst_left == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    function automatic t_plan_row row(t_row_op op, logic [APB_DW-1:0] value, logic kind,
                                      logic [SEQ_W-1:0] seq, bit typed, t_result want);
        t_plan_row p;
        p.op    = op;
        p.value = value;
        p.req   = '{kind, seq};
        p.typed = typed;
        p.want  = want;
        return p;
    endfunction

    initial begin
        t_request    r;
        int          counted;
        int          phase_len;
        int          pick;
        int unsigned w;
        int unsigned tot;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_window = WIN_RESET;
        cfg_total  = '0;
        win_base   = 0;
        foreach (acked[k]) acked[k] = 1'b0;
        mismatches = 0;
        burst_left = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        plan.push_back(row(ROW_ITEM, 0, REQ_ROUND, 16'd0, 1, status(16'd0, 1'b1)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd0, 1, status(16'd0, 1'b1)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'hFFFF, 1, status(16'd0, 1'b1)));
        plan.push_back(row(ROW_SET_TOTAL, 6, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd2, 1, status(16'd0, 1'b0)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd2, 1, status(16'd0, 1'b0)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd0, 1, status(16'd1, 1'b0)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd1, 1, status(16'd3, 1'b0)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd9, 1, status(16'd3, 1'b0)));
        plan.push_back(row(ROW_SET_WINDOW, 0, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd4, 1, status(16'd3, 1'b0)));
        plan.push_back(row(ROW_SET_WINDOW, 15, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd5, 1, status(16'd3, 1'b0)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd4, 1, status(16'd3, 1'b0)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd3, 1, status(16'd6, 1'b1)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ROUND, 16'd0, 1, status(16'd6, 1'b1)));
        plan.push_back(row(ROW_SET_TOTAL, 65535, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_SET_WINDOW, 8, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd13, 1, status(16'd6, 1'b0)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'hFFFF, 1, status(16'd6, 1'b0)));
        plan.push_back(row(ROW_ITEM, 0, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_SET_TOTAL, 3, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ROUND, 16'd0, 1, status(16'd6, 1'b1)));
        plan.push_back(row(ROW_SET_WINDOW, 1, REQ_ROUND, 16'd0, 0, '0));
        plan.push_back(row(ROW_ITEM, 0, REQ_ACK, 16'd6, 1, status(16'd6, 1'b1)));

        foreach (plan[k]) begin
            case (plan[k].op)
                ROW_ITEM: begin
                    sender_gap();
                    send_item(plan[k].req, plan[k].typed, plan[k].want);
                end
                ROW_SET_WINDOW: begin
                    wait_idle();
                    apb_write(ADDR_WINDOW, plan[k].value);
                end
                default: begin
                    wait_idle();
                    apb_write(ADDR_TOTAL, plan[k].value);
                end
            endcase
        end

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            wait_idle();
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                apb_write(ADDR_WINDOW, 0);
            end else if (pick < 4) begin
                apb_write(ADDR_WINDOW, 8);
            end else if (pick < 5) begin
                apb_write(ADDR_WINDOW, 15);
            end else begin
                apb_write(ADDR_WINDOW, $urandom_range(1, 15));
            end
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                tot = win_base + $urandom_range(1, 24);
                apb_write(ADDR_TOTAL, (tot > 65535) ? 65535 : tot);
            end else if (pick < 17) begin
                apb_write(ADDR_TOTAL, 65535);
            end else begin
                apb_write(ADDR_TOTAL, $urandom_range(0, win_base));
            end
            phase_len = $urandom_range(6, 18);
            for (int n = 0; n < phase_len && counted < RANDOM_ITEMS; n++) begin
                w    = eff_window();
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    r = '{REQ_ROUND, SEQ_W'($urandom_range(0, 65535))};
                end else if (pick < 85) begin
                    r = '{REQ_ACK, SEQ_W'(win_base + $urandom_range(0, w - 1))};
                end else if (pick < 93) begin
                    r = '{REQ_ACK, SEQ_W'($urandom_range(0, 65535))};
                end else begin
                    r = '{REQ_ACK, SEQ_W'(cfg_total + $urandom_range(0, 3))};
                end
                sender_gap();
                send_item(r, 1'b0, '0);
                counted++;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/srsw_pkg.sv
hdl/srsw_cell.sv
hdl/selective_repeat_sender_window_top.sv
tb/testbench.sv
